/* hdl/wavhp_pkg.sv */
// Package for the WAV header chunk parser.
// Holds the parse phase type, tag and status constants and the result word struct.
// No dependencies.
package wavhp_pkg;

    // Parse phases of the byte walker.
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_CHUNK  = 3'd1,
        PH_FMT    = 3'd2,
        PH_SKIP   = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    // Status codes of a result word.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_HDR = 3'd1;
    localparam logic [2:0] ST_SHORT   = 3'd2;
    localparam logic [2:0] ST_TRUNC   = 3'd3;
    localparam logic [2:0] ST_ZERO    = 3'd4;

    // Four-character tags as they appear after little-endian assembly.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Layout constants of the file format.
    localparam logic [31:0] HEADER_BYTES = 32'd12;
    localparam logic [31:0] FMT_BYTES    = 32'd16;
    localparam logic [31:0] CHUNK_HDR_BYTES = 32'd8;

    // One result word.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [15:0] sample_bits;
        logic [31:0] data_offset;
        logic [31:0] data_length;
    } res_t;

endpackage

/* hdl/wavhp_parse_core.sv */
// Byte-walking parser state and its single-pass next-state logic.
// Produces at most one result word per consumed byte.
// Depends on wavhp_pkg.
module wavhp_parse_core
    import wavhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        res_fire,
    output res_t        res
);

    // Byte positions inside the headers and the fmt body.
    localparam logic [3:0] POS_RIFF_END = 4'd3;
    localparam logic [3:0] POS_WAVE_END = 4'd11;
    localparam logic [3:0] POS_TAG_LEN  = 4'd4;
    localparam logic [3:0] POS_CHDR_END = 4'd7;
    localparam logic [3:0] POS_FMT_END  = 4'd15;

    phase_t      phase_reg,  phase_next;
    logic [3:0]  cnt_reg,    cnt_next;
    logic [31:0] tag_reg,    tag_next;
    logic [31:0] len_reg,    len_next;
    logic [32:0] skip_reg,   skip_next;
    logic [31:0] rate_reg,   rate_next;
    logic [15:0] chan_reg,   chan_next;
    logic [15:0] bits_reg,   bits_next;
    logic [31:0] offset_reg, offset_next;

    logic [31:0] tag_shift;
    logic [31:0] len_shift;
    logic [32:0] skip_val;
    logic [32:0] skip_dec;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            cnt_reg    <= '0;
            tag_reg    <= '0;
            len_reg    <= '0;
            skip_reg   <= '0;
            rate_reg   <= '0;
            chan_reg   <= '0;
            bits_reg   <= '0;
            offset_reg <= HEADER_BYTES;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            tag_reg    <= tag_next;
            len_reg    <= len_next;
            skip_reg   <= skip_next;
            rate_reg   <= rate_next;
            chan_reg   <= chan_next;
            bits_reg   <= bits_next;
            offset_reg <= offset_next;
        end
    end

    // Next state and result for the byte at the input.
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        tag_next    = tag_reg;
        len_next    = len_reg;
        skip_next   = skip_reg;
        rate_next   = rate_reg;
        chan_next   = chan_reg;
        bits_next   = bits_reg;
        offset_next = offset_reg;
        res_fire    = 1'b0;
        res         = '0;
        skip_val    = '0;
        skip_dec    = '0;
        tag_shift   = {data_byte, tag_reg[31:8]};
        len_shift   = {data_byte, len_reg[31:8]};

        case (phase_reg)
            PH_HEADER:
            begin
                tag_next = tag_shift;
                cnt_next = cnt_reg + 4'd1;
                if ((cnt_reg == POS_RIFF_END && tag_shift != TAG_RIFF) ||
                    (cnt_reg == POS_WAVE_END && tag_shift != TAG_WAVE))
                begin
                    res_fire   = 1'b1;
                    res.status = ST_BAD_HDR;
                    phase_next = PH_DONE;
                end
                else if (cnt_reg == POS_WAVE_END)
                begin
                    phase_next = PH_CHUNK;
                    cnt_next   = '0;
                end
            end

            PH_CHUNK:
            begin
                if (cnt_reg < POS_TAG_LEN)
                begin
                    tag_next = tag_shift;
                end
                else
                begin
                    len_next = len_shift;
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == POS_CHDR_END)
                begin
                    cnt_next = '0;
                    if (tag_reg == TAG_DATA)
                    begin
                        // Data chunk header complete: report the format.
                        res_fire = 1'b1;
                        res.status = (rate_reg == '0 || chan_reg == '0 || bits_reg == '0)
                                     ? ST_ZERO : ST_OK;
                        res.sample_rate   = rate_reg;
                        res.channel_count = chan_reg;
                        res.sample_bits   = bits_reg;
                        res.data_offset   = offset_reg + CHUNK_HDR_BYTES;
                        res.data_length   = len_shift;
                        phase_next        = PH_DONE;
                    end
                    else if (tag_reg == TAG_FMT && len_shift < FMT_BYTES)
                    begin
                        res_fire   = 1'b1;
                        res.status = ST_SHORT;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        // Next chunk starts after this header, the body and its pad.
                        offset_next = offset_reg + CHUNK_HDR_BYTES + len_shift
                                      + {31'd0, len_shift[0]};
                        if (tag_reg == TAG_FMT)
                        begin
                            phase_next = PH_FMT;
                        end
                        else
                        begin
                            skip_val   = {1'b0, len_shift} + {32'd0, len_shift[0]};
                            skip_next  = skip_val;
                            phase_next = (skip_val == '0) ? PH_CHUNK : PH_SKIP;
                        end
                    end
                end
            end

            PH_FMT:
            begin
                case (cnt_reg)
                    4'd2:    chan_next = {chan_reg[15:8], data_byte};
                    4'd3:    chan_next = {data_byte, chan_reg[7:0]};
                    4'd4:    rate_next = {rate_reg[31:8], data_byte};
                    4'd5:    rate_next = {rate_reg[31:16], data_byte, rate_reg[7:0]};
                    4'd6:    rate_next = {rate_reg[31:24], data_byte, rate_reg[15:0]};
                    4'd7:    rate_next = {data_byte, rate_reg[23:0]};
                    4'd14:   bits_next = {bits_reg[15:8], data_byte};
                    4'd15:   bits_next = {data_byte, bits_reg[7:0]};
                    default: ;
                endcase
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == POS_FMT_END)
                begin
                    // Skip the rest of the fmt body and its pad byte.
                    skip_val   = {1'b0, len_reg - FMT_BYTES} + {32'd0, len_reg[0]};
                    skip_next  = skip_val;
                    phase_next = (skip_val == '0) ? PH_CHUNK : PH_SKIP;
                    cnt_next   = '0;
                end
            end

            PH_SKIP:
            begin
                skip_dec   = (skip_reg != '0) ? skip_reg - 33'd1 : skip_reg;
                skip_next  = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = PH_CHUNK;
                end
                cnt_next = '0;
            end

            default: ;
        endcase

        // A file that ends before any result reports truncation.
        if (!res_fire && last_byte && phase_reg != PH_DONE)
        begin
            res_fire   = 1'b1;
            res        = '0;
            res.status = ST_TRUNC;
        end

        // The last byte of a file rearms the parser.
        if (last_byte)
        begin
            phase_next  = PH_HEADER;
            cnt_next    = '0;
            tag_next    = '0;
            len_next    = '0;
            skip_next   = '0;
            rate_next   = '0;
            chan_next   = '0;
            bits_next   = '0;
            offset_next = HEADER_BYTES;
        end
    end

endmodule

/* hdl/wavhp_out_reg.sv */
// Result register of the WAV header chunk parser.
// Holds one result word until the downstream side takes it.
// Depends on wavhp_pkg.
module wavhp_out_reg
    import wavhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  res_t        res,
    input  logic        out_stall,
    output logic        busy,
    output logic        out_valid,
    output logic [2:0]  status,
    output logic [31:0] sample_rate,
    output logic [15:0] channel_count,
    output logic [15:0] sample_bits,
    output logic [31:0] data_offset,
    output logic [31:0] data_length
);

    logic out_vld_reg, out_vld_next;
    res_t res_reg;

    // Valid flag: set on load, cleared once the word is taken.
    always_comb
    begin
        if (load)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign busy          = out_vld_reg && out_stall;
    assign out_valid     = out_vld_reg;
    assign status        = res_reg.status;
    assign sample_rate   = res_reg.sample_rate;
    assign channel_count = res_reg.channel_count;
    assign sample_bits   = res_reg.sample_bits;
    assign data_offset   = res_reg.data_offset;
    assign data_length   = res_reg.data_length;

endmodule

/* hdl/wav_header_chunk_parser.sv */
// WAV header chunk parser, top level: input register, parse core, result register.
// A result word goes from the input register through the combinational parse step into the result register.
// Throughput: one byte per cycle; a byte that
// yields a result waits in the input register only while the result register is held.
// Reset: asynchronous, active low; the parser waits for a RIFF header, no word pending.
// Depends on wavhp_pkg, wavhp_parse_core and wavhp_out_reg.
module wav_header_chunk_parser
    import wavhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] sample_rate,
    output logic [15:0] channel_count,
    output logic [15:0] sample_bits,
    output logic [31:0] data_offset,
    output logic [31:0] data_length
);

    logic       in_vld_reg, in_vld_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       advance;
    logic       res_fire;
    logic       out_busy;
    res_t       res;

    // A held byte moves on unless it yields a result and the result register is held.
    assign advance  = in_vld_reg && (!res_fire || !out_busy);
    assign in_stall = in_vld_reg && !advance;

    // Input register valid flag.
    always_comb
    begin
        if (!in_stall)
        begin
            in_vld_next = in_valid;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    wavhp_parse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (byte_reg),
        .last_byte (last_reg),
        .res_fire  (res_fire),
        .res       (res)
    );

    wavhp_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && res_fire),
        .res           (res),
        .out_stall     (out_stall),
        .busy          (out_busy),
        .out_valid     (out_valid),
        .status        (status),
        .sample_rate   (sample_rate),
        .channel_count (channel_count),
        .sample_bits   (sample_bits),
        .data_offset   (data_offset),
        .data_length   (data_length)
    );

endmodule
